// ----- src/rle_pattern_run_decoder_core_assert.svh -----
// Assertion macros for the run-length pattern decoder.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef RLE_PATTERN_RUN_DECODER_CORE_ASSERT_SVH
`define RLE_PATTERN_RUN_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define RPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rpd_pkg.sv -----
// Shared types and constants for the run-length pattern decoder.
// No dependencies.
package rpd_pkg;

   localparam int COORD_BITS = 16;
   localparam logic [15:0] COORD_MAX = (COORD_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << COORD_BITS) - 32'd1);

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_COLS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_ROWS = 1'd1;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ROW_END = 8'h24;
   localparam logic [7:0] CHAR_PAT_END = 8'h21;
   localparam logic [7:0] CHAR_PAD     = 8'h62;

   typedef struct packed {
      logic [11:0] grid_cols;
      logic [11:0] grid_rows;
   } rpd_cfg_type;

   typedef struct packed {
      logic [15:0] repeat_count;
      logic        count_seen;
      logic [15:0] current_row;
      logic [15:0] current_col;
   } rpd_state_type;

   typedef struct packed {
      logic [7:0]  cell_symbol;
      logic [15:0] row_index;
      logic [15:0] col_start;
      logic [15:0] run_length;
      logic [15:0] rows_spanned;
      logic        pattern_done;
      logic        last_of_item;
   } rpd_result_type;

endpackage

// ----- src/rle_pattern_run_decoder_core.sv -----
// Run-length pattern body decoder: input register, character decode, result register.
// Depends on rpd_pkg, rpd_csr, rpd_decode and rle_pattern_run_decoder_core_assert.svh.
//
// Use: pattern body characters enter on req_ one per word; req_tlast marks the
// last character and ends the pattern like '!'. Each run leaves on rsp_ as one
// word (symbol, row, column, length, rows spanned); rsp_tlast marks the last
// run of a pattern, rsp_tuser the last run caused by one character.
// Grid width and height are written on csr_ (index 0 cols, 1 rows) while idle.
// A character is held in the input register, its runs then in the result register.
// Throughput: one character per cycle unless rsp_tready stalls; a character that
// causes n results holds the decode register until all have left, as the result
// register takes one run per cycle. Digits and blanks give no result unless last.
// Reset clears the grid size, the pending count and the row and column.
// When the receiver stalls, the result register holds its word and the
// character being decoded waits, so req_tready drops once both are full.
module rle_pattern_run_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] char_code
   input  logic                               req_tlast,   // final_char
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] cell_symbol, [23:8] row_index, [39:24] col_start,
   // [55:40] run_length, [71:56] rows_spanned
   output logic [71:0]                        rsp_tdata,
   output logic                               rsp_tlast,   // pattern_done
   output logic                               rsp_tuser,   // last_of_item
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [11:0]                        csr_wdata
);
   import rpd_pkg::*;

   rpd_cfg_type    cfg;
   rpd_state_type  state_ff, state_in, state_next;
   rpd_result_type res [3];
   rpd_result_type rsp_ff, rsp_in;
   logic [1:0]     res_cnt, idx_ff, idx_in;
   logic           pat_end;
   logic           item_valid_ff, item_valid_in;
   logic [7:0]     char_ff, char_in;
   logic           final_ff, final_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free, has_res, last_sel, item_done, load, req_accept;

   rpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpd_decode u_decode (
      .char_code  (char_ff),
      .final_char (final_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .res        (res),
      .res_cnt    (res_cnt),
      .pat_end    (pat_end),
      .state_next (state_next)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign has_res    = (res_cnt != 2'd0);
   assign last_sel   = (idx_ff == res_cnt - 2'd1);
   assign item_done  = item_valid_ff && (!has_res || (out_free && last_sel));
   assign load       = item_valid_ff && has_res && out_free;
   assign req_tready = !item_valid_ff || item_done;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      char_in       = char_ff;
      final_in      = final_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
         char_in       = req_tdata;
         final_in      = req_tlast;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end

      idx_in = item_done ? 2'd0 : (load ? idx_ff + 2'd1 : idx_ff);
      state_in = item_done ? state_next : state_ff;

      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_in = rsp_ff;
      if (load) begin
         unique case (idx_ff)
            2'd0:    rsp_in = res[0];
            2'd1:    rsp_in = res[1];
            default: rsp_in = res[2];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff  <= char_in;
      final_ff <= final_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.rows_spanned, rsp_ff.run_length, rsp_ff.col_start,
                        rsp_ff.row_index, rsp_ff.cell_symbol};
   assign rsp_tlast  = rsp_ff.pattern_done;
   assign rsp_tuser  = rsp_ff.last_of_item;

`include "rle_pattern_run_decoder_core_assert.svh"

   `RPD_ASSERT_NOW(a_idx_in_range, item_valid_ff && has_res, idx_ff < res_cnt, "bad run index")
   `RPD_ASSERT_NEXT(a_state_hold, !item_done, state_ff == $past(state_ff), "state moved mid item")
   `RPD_ASSERT_NEXT(a_end_clears, item_done && pat_end, state_ff == '0, "state kept after end")
   `RPD_ASSERT_NOW(a_done_is_last, rsp_valid_ff && rsp_tlast, rsp_tuser, "end not last run")

endmodule

// ----- src/rpd_csr.sv -----
// Configuration registers (grid width and height) of the pattern decoder.
// Depends on rpd_pkg.
module rpd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [11:0]                        csr_wdata,
   output rpd_pkg::rpd_cfg_type               cfg
);
   import rpd_pkg::*;

   rpd_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_COLS: cfg_in.grid_cols = csr_wdata;
            REG_GRID_ROWS: cfg_in.grid_rows = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/rpd_decode.sv -----
// Decode of one pattern character: up to three runs and the next decoder state.
// Purely combinational; depends on rpd_pkg.
module rpd_decode (
   input  logic [7:0]                   char_code,
   input  logic                         final_char,
   input  rpd_pkg::rpd_state_type       state,
   input  rpd_pkg::rpd_cfg_type         cfg,
   output rpd_pkg::rpd_result_type      res [3],
   output logic [1:0]                   res_cnt,
   output logic                         pat_end,
   output rpd_pkg::rpd_state_type       state_next
);
   import rpd_pkg::*;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COORD_MAX}) ? COORD_MAX : s[15:0];
   endfunction

   function automatic rpd_result_type mk(input logic [7:0] sym, input logic [15:0] row,
                                         input logic [15:0] col, input logic [15:0] len,
                                         input logic [15:0] span);
      rpd_result_type r;
      r.cell_symbol  = sym;
      r.row_index    = row;
      r.col_start    = col;
      r.run_length   = len;
      r.rows_spanned = span;
      r.pattern_done = 1'b0;
      r.last_of_item = 1'b0;
      return r;
   endfunction

   logic        is_digit, is_blank, is_row_end, is_end_char, is_symbol;
   logic [15:0] cols16, rows16;
   logic [19:0] digit_acc;
   logic [15:0] count_sat, n_run, n_row;
   logic [15:0] row_mid, col_mid;
   logic [15:0] pad_cur, pad_mid, span_blk, span_rest;
   logic [16:0] row_mid_p1;
   logic [1:0]  main_cnt, fin_cnt;
   rpd_result_type m0, m1, f0, f1;
   rpd_result_type pick [3];

   assign cols16 = {4'd0, cfg.grid_cols};
   assign rows16 = {4'd0, cfg.grid_rows};

   assign is_digit    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_blank    = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                        (char_code == CHAR_LF) || (char_code == CHAR_CR);
   assign is_end_char = (char_code == CHAR_PAT_END);
   assign is_row_end  = (char_code == CHAR_ROW_END);
   assign is_symbol   = !is_digit && !is_blank && !is_end_char && !is_row_end;
   assign pat_end     = final_char || is_end_char;

   // count * 10 + digit
   assign digit_acc = {1'b0, state.repeat_count, 3'd0} + {3'd0, state.repeat_count, 1'b0}
                      + {16'd0, char_code[3:0]};
   assign count_sat = (digit_acc > 20'h0FFFF) ? 16'hFFFF : digit_acc[15:0];

   assign n_run = state.count_seen ? state.repeat_count : 16'd1;
   assign n_row = (n_run == 16'd0) ? 16'd1 : n_run;

   assign row_mid = is_row_end ? sat_add(state.current_row, n_row) : state.current_row;
   assign col_mid = is_row_end ? 16'd0 :
                    is_symbol  ? sat_add(state.current_col, n_run) : state.current_col;

   assign pad_cur    = (state.current_col < cols16) ? cols16 - state.current_col : 16'd0;
   assign pad_mid    = (col_mid < cols16) ? cols16 - col_mid : 16'd0;
   assign span_blk   = (rows16 > row_mid) ? rows16 - row_mid : 16'd1;
   assign row_mid_p1 = {1'b0, row_mid} + 17'd1;
   assign span_rest  = rows16 - row_mid - 16'd1;

   always_comb begin
      m0 = mk(char_code, state.current_row, state.current_col, n_run, 16'd1);
      m1 = mk(CHAR_PAD, sat_add(state.current_row, 16'd1), 16'd0, cols16, n_row - 16'd1);
      main_cnt = 2'd0;
      if (is_row_end) begin
         m0 = mk(CHAR_PAD, state.current_row, state.current_col, pad_cur, 16'd1);
         main_cnt = (n_row > 16'd1) ? 2'd2 : 2'd1;
      end else if (is_symbol) begin
         main_cnt = 2'd1;
      end

      if (col_mid == 16'd0) begin
         f0 = mk(CHAR_PAD, row_mid, 16'd0, cols16, span_blk);
         fin_cnt = 2'd1;
      end else begin
         f0 = mk(CHAR_PAD, row_mid, col_mid, pad_mid, 16'd1);
         fin_cnt = (row_mid_p1 < {1'b0, rows16}) ? 2'd2 : 2'd1;
      end
      f1 = mk(CHAR_PAD, sat_add(row_mid, 16'd1), 16'd0, cols16, span_rest);
      if (!pat_end) fin_cnt = 2'd0;

      unique case (main_cnt)
         2'd0: begin
            pick[0] = f0; pick[1] = f1; pick[2] = f1;
         end
         2'd1: begin
            pick[0] = m0; pick[1] = f0; pick[2] = f1;
         end
         default: begin
            pick[0] = m0; pick[1] = m1; pick[2] = f0;
         end
      endcase

      res_cnt = main_cnt + fin_cnt;
      for (int i = 0; i < 3; i++) begin
         res[i] = pick[i];
         res[i].last_of_item = (2'(i) == res_cnt - 2'd1);
         res[i].pattern_done = res[i].last_of_item && pat_end;
      end

      state_next = state;
      if (pat_end) begin
         state_next = '0;
      end else if (is_digit) begin
         state_next.repeat_count = count_sat;
         state_next.count_seen   = 1'b1;
      end else if (is_row_end || is_symbol) begin
         state_next.repeat_count = 16'd0;
         state_next.count_seen   = 1'b0;
         state_next.current_row  = row_mid;
         state_next.current_col  = col_mid;
      end
   end

endmodule
